[sv/fdd_pkg.sv]
// ----------------------------------------------------------------------------
// fdd_pkg
// Shared types and constants for the finite difference derivative block:
// datapath widths, status codes, controller states and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
package fdd_pkg;

    // field width and internal working widths (sized for fields of 32 bits)
    localparam int MAX_W  = 32;   // width of the sample and result fields
    localparam int MAG_W  = 36;   // differences and their magnitudes
    localparam int MUL_W  = 33;   // multiplier operand width
    localparam int PROD_W = 66;   // multiplier product, divisor width
    localparam int QSTEPS = 43;   // quotient bits produced by the divider
    localparam int Q_W    = 43;   // quotient register width
    localparam int NUM_W  = 108;  // dividend / shifted divisor width
    localparam int VAL_W  = 44;   // signed value before saturation
    localparam int CNT_W  = 6;    // divider step counter

    // quotient magnitude clamp
    localparam logic [Q_W-1:0] BIG_MAG = Q_W'(1) << 40;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZDIV = 2'd2;
    localparam logic [1:0] ST_FEW  = 2'd3;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_PREP,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_COMMIT,
        S_HWRITE,
        S_EMIT_END,
        S_EMIT_H0,
        S_EMIT_H1,
        S_SHORT,
        S_FINISH
    } state_t;

    // which quotient the datapath is working on
    typedef enum logic [1:0] {
        OP_INT_D1,
        OP_INT_D2,
        OP_EXT_D1,
        OP_EXT_D2
    } op_t;

    // where a result transfer takes its fields from
    typedef enum logic [1:0] {
        SRC_SHORT,
        SRC_H0,
        SRC_H1,
        SRC_END
    } src_t;

    // job being sequenced: interior point, first end, final end
    typedef enum logic [1:0] {
        PH_INT,
        PH_END0,
        PH_END1
    } phase_t;

    typedef struct packed {
        logic       accept;
        logic       hist_shift;
        logic       prep;
        op_t        op;
        logic       end_sel;
        logic       mul;
        logic       div_start;
        logic       commit;
        logic       hist_write;
        logic       emit;
        src_t       emit_src;
        logic [1:0] emit_idx;
        logic       emit_last;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic [2:0] count;
        logic       last_in;
        logic       div_done;
        logic       out_free;
    } stat_t;

    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    function automatic logic [1:0] max_st(input logic [1:0] a, input logic [1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

[sv/fdd_div.sv]
// ----------------------------------------------------------------------------
// fdd_div
// Shared restoring divider: one quotient bit per cycle, most significant
// first, over QSTEPS steps; the datapath clamps an oversized quotient.
// ----------------------------------------------------------------------------
module fdd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fdd_pkg::NUM_W-1:0]  num,
    input  logic [fdd_pkg::PROD_W-1:0] den,
    output logic                      done,
    output logic [fdd_pkg::Q_W-1:0]    quot
);
    import fdd_pkg::*;

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ge;

    // one compare and subtract per step
    always_comb
    begin
        ge        = rem_reg >= dsh_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = busy_reg && (cnt_reg == CNT_W'(1));
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NUM_W'(den) << (QSTEPS - 1);
            quot_next = '0;
            cnt_next  = CNT_W'(QSTEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[Q_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[sv/fdd_datapath.sv]
// ----------------------------------------------------------------------------
// fdd_datapath
// Sample windows, derivative history, operand setup, shared multiplier and
// divider, result saturation and the output register.
// ----------------------------------------------------------------------------
module fdd_datapath #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fdd_pkg::cmd_t      cmd,
    output fdd_pkg::stat_t     stat,
    input  logic signed [31:0] x_sample,
    input  logic signed [31:0] y_sample,
    input  logic               last_point,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [31:0] x_out,
    output logic signed [31:0] first_deriv,
    output logic signed [31:0] second_deriv,
    output logic [1:0]         status,
    output logic               last_result
);
    import fdd_pkg::*;

    localparam int EW = (DATA_WIDTH < MAX_W) ? DATA_WIDTH : MAX_W;
    localparam int SH = MAX_W - EW;
    localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'((64'sd1 <<< (EW - 1)) - 64'sd1);
    localparam logic signed [VAL_W-1:0] SAT_LO = -SAT_HI - VAL_W'(1);

    // input and window state
    logic signed [31:0] x_in_reg, y_in_reg;
    logic               last_in_reg;
    logic signed [31:0] xw_reg [3];
    logic signed [31:0] yw_reg [3];
    logic signed [31:0] hist1_reg [2];
    logic signed [31:0] hist2_reg [2];
    logic [1:0]         held_reg [2];
    logic [2:0]         count_reg;

    // job registers
    logic [NUM_W-1:0]   num_reg;
    logic [PROD_W-1:0]  den_reg;
    logic [MUL_W-1:0]   fa_reg, fb_reg;
    logic               neg_reg;
    logic signed [31:0] base_reg;
    logic [1:0]         acc_reg;
    logic signed [31:0] res1_reg, res2_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] x_out_reg, d1_out_reg, d2_out_reg;
    logic [1:0]         st_out_reg;
    logic               last_out_reg;

    logic signed [31:0] x_shl, y_shl, x_sx, y_sx;
    logic signed [31:0] xa, xb, xc, ya, yb, yc, xnear, xfar, xt, dnear, dfar;
    logic signed [MAG_W-1:0] dy, dx, nn, dxr, dxl, dd, dt, ds;
    logic               near_i, far_i, is_ext, is_d1, slot;
    logic [PROD_W-1:0]  prod;
    logic               div_done;
    logic [Q_W-1:0]     quot, m_clamp;
    logic               num_zero, den_zero;
    logic [VAL_W-1:0]   sq;
    logic signed [VAL_W-1:0] sval, sum;
    logic signed [31:0] res;
    logic [1:0]         code, acc_new;

    // sign extension from the active data width
    always_comb
    begin
        x_shl = x_sample <<< SH;
        y_shl = y_sample <<< SH;
        x_sx  = x_shl >>> SH;
        y_sx  = y_shl >>> SH;
    end

    // operand selection and differences
    always_comb
    begin
        is_ext = (cmd.op == OP_EXT_D1) || (cmd.op == OP_EXT_D2);
        is_d1  = (cmd.op == OP_INT_D1) || (cmd.op == OP_EXT_D1);
        slot   = (count_reg != 3'd2);
        xa = slot ? xw_reg[1] : xw_reg[0];
        xb = slot ? xw_reg[2] : xw_reg[1];
        xc = x_in_reg;
        ya = slot ? yw_reg[1] : yw_reg[0];
        yb = slot ? yw_reg[2] : yw_reg[1];
        yc = y_in_reg;
        near_i = cmd.end_sel;
        far_i  = !cmd.end_sel;
        xnear  = cmd.end_sel ? xw_reg[2] : xw_reg[1];
        xfar   = cmd.end_sel ? xw_reg[1] : xw_reg[2];
        xt     = cmd.end_sel ? x_in_reg : xw_reg[0];
        dnear  = is_d1 ? hist1_reg[near_i] : hist2_reg[near_i];
        dfar   = is_d1 ? hist1_reg[far_i] : hist2_reg[far_i];
        dy  = MAG_W'(yc) - MAG_W'(ya);
        dx  = MAG_W'(xc) - MAG_W'(xa);
        nn  = MAG_W'(yc) + MAG_W'(ya) - (MAG_W'(yb) <<< 1);
        dxr = MAG_W'(xc) - MAG_W'(xb);
        dxl = MAG_W'(xb) - MAG_W'(xa);
        dd  = MAG_W'(dfar) - MAG_W'(dnear);
        dt  = MAG_W'(xt) - MAG_W'(xnear);
        ds  = MAG_W'(xfar) - MAG_W'(xnear);
    end

    // shared multiplier
    assign prod = PROD_W'(fa_reg) * PROD_W'(fb_reg);

    fdd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // quotient sign, zero spacing, base add and saturation
    always_comb
    begin
        num_zero = (num_reg == '0);
        den_zero = (den_reg == '0);
        m_clamp  = (quot > BIG_MAG) ? BIG_MAG : quot;
        if (num_zero)
        begin
            sq = '0;
        end
        else if (den_zero)
        begin
            sq = {1'b0, BIG_MAG};
        end
        else
        begin
            sq = {1'b0, m_clamp};
        end
        sval = neg_reg ? -$signed(sq) : $signed(sq);
        sum  = VAL_W'(base_reg) + sval;
        code = den_zero ? ST_ZDIV : ST_OK;
        if (sum > SAT_HI)
        begin
            res  = SAT_HI[31:0];
            code = max_st(code, ST_SAT);
        end
        else if (sum < SAT_LO)
        begin
            res  = SAT_LO[31:0];
            code = max_st(code, ST_SAT);
        end
        else
        begin
            res = sum[31:0];
        end
        acc_new = max_st(acc_reg, code);
    end

    // sample count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                if (last_in_reg)
                begin
                    count_reg <= '0;
                end
                else if (count_reg < 3'd3)
                begin
                    count_reg <= count_reg + 3'd1;
                end
                else
                begin
                    count_reg <= 3'd4;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // windows, history and job registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_in_reg    <= x_sx;
            y_in_reg    <= y_sx;
            last_in_reg <= last_point;
            if (count_reg < 3'd3)
            begin
                xw_reg[count_reg[1:0]] <= x_sx;
                yw_reg[count_reg[1:0]] <= y_sx;
            end
        end
        if (cmd.finish && (count_reg >= 3'd3))
        begin
            xw_reg[0] <= xw_reg[1];
            xw_reg[1] <= xw_reg[2];
            xw_reg[2] <= x_in_reg;
            yw_reg[0] <= yw_reg[1];
            yw_reg[1] <= yw_reg[2];
            yw_reg[2] <= y_in_reg;
        end
        if (cmd.hist_shift)
        begin
            hist1_reg[0] <= hist1_reg[1];
            hist2_reg[0] <= hist2_reg[1];
            held_reg[0]  <= held_reg[1];
        end
        if (cmd.hist_write)
        begin
            hist1_reg[slot] <= res1_reg;
            hist2_reg[slot] <= res2_reg;
            held_reg[slot]  <= acc_reg;
        end
        // operand setup
        if (cmd.prep)
        begin
            case (cmd.op)
                OP_INT_D1:
                begin
                    num_reg  <= NUM_W'(mag(dy)) << FRAC_BITS;
                    fa_reg   <= MUL_W'(mag(dx));
                    fb_reg   <= MUL_W'(1);
                    neg_reg  <= dy[MAG_W-1] ^ dx[MAG_W-1];
                    base_reg <= '0;
                    acc_reg  <= ST_OK;
                end
                OP_INT_D2:
                begin
                    num_reg  <= NUM_W'(mag(nn)) << (2 * FRAC_BITS);
                    fa_reg   <= MUL_W'(mag(dxr));
                    fb_reg   <= MUL_W'(mag(dxl));
                    neg_reg  <= nn[MAG_W-1] ^ dxr[MAG_W-1] ^ dxl[MAG_W-1];
                    base_reg <= '0;
                end
                default:
                begin
                    den_reg  <= PROD_W'(mag(ds));
                    fa_reg   <= MUL_W'(mag(dd));
                    fb_reg   <= MUL_W'(mag(dt));
                    neg_reg  <= dd[MAG_W-1] ^ dt[MAG_W-1] ^ ds[MAG_W-1];
                    base_reg <= dnear;
                    if (is_d1)
                    begin
                        acc_reg <= max_st(held_reg[0], held_reg[1]);
                    end
                end
            endcase
        end
        // product goes to dividend or divisor
        if (cmd.mul)
        begin
            if (is_ext)
            begin
                num_reg <= NUM_W'(prod);
            end
            else
            begin
                den_reg <= prod;
            end
        end
        if (cmd.commit)
        begin
            acc_reg <= acc_new;
            if (is_d1)
            begin
                res1_reg <= res;
            end
            else
            begin
                res2_reg <= res;
            end
        end
        // result transfer fields
        if (cmd.emit)
        begin
            case (cmd.emit_src)
                SRC_SHORT:
                begin
                    x_out_reg    <= xw_reg[cmd.emit_idx];
                    d1_out_reg   <= '0;
                    d2_out_reg   <= '0;
                    st_out_reg   <= ST_FEW;
                    last_out_reg <= cmd.emit_last;
                end
                SRC_H0:
                begin
                    x_out_reg    <= xw_reg[1];
                    d1_out_reg   <= hist1_reg[0];
                    d2_out_reg   <= hist2_reg[0];
                    st_out_reg   <= held_reg[0];
                    last_out_reg <= 1'b0;
                end
                SRC_H1:
                begin
                    x_out_reg    <= xw_reg[2];
                    d1_out_reg   <= hist1_reg[1];
                    d2_out_reg   <= hist2_reg[1];
                    st_out_reg   <= held_reg[1];
                    last_out_reg <= 1'b0;
                end
                default:
                begin
                    x_out_reg    <= xt;
                    d1_out_reg   <= res1_reg;
                    d2_out_reg   <= res2_reg;
                    st_out_reg   <= acc_reg;
                    last_out_reg <= cmd.emit_last;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.count    = count_reg;
        stat.last_in  = last_in_reg;
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign x_out        = x_out_reg;
    assign first_deriv  = d1_out_reg;
    assign second_deriv = d2_out_reg;
    assign status       = st_out_reg;
    assign last_result  = last_out_reg;

endmodule

[sv/fdd_ctrl.sv]
// ----------------------------------------------------------------------------
// fdd_ctrl
// Sequencer: takes one point, runs the quotient jobs for the interior point
// and the end points, and orders the result transfers.
// ----------------------------------------------------------------------------
module fdd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fdd_pkg::stat_t stat,
    output fdd_pkg::cmd_t  cmd
);
    import fdd_pkg::*;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       d2_reg, d2_next;
    logic [1:0] idx_reg, idx_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        d2_next    = d2_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        if (phase_reg == PH_INT)
        begin
            cmd.op = d2_reg ? OP_INT_D2 : OP_INT_D1;
        end
        else
        begin
            cmd.op = d2_reg ? OP_EXT_D2 : OP_EXT_D1;
        end
        cmd.end_sel  = (phase_reg == PH_END1);
        cmd.emit_idx = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    idx_next   = '0;
                    phase_next = PH_INT;
                    d2_next    = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.count < 3'd2)
                begin
                    state_next = stat.last_in ? S_SHORT : S_FINISH;
                end
                else
                begin
                    cmd.hist_shift = (stat.count == 3'd4);
                    state_next     = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (!d2_reg)
                begin
                    d2_next    = 1'b1;
                    state_next = S_PREP;
                end
                else if (phase_reg == PH_INT)
                begin
                    state_next = S_HWRITE;
                end
                else
                begin
                    state_next = S_EMIT_END;
                end
            end
            S_HWRITE:
            begin
                cmd.hist_write = 1'b1;
                if (stat.count == 3'd2)
                begin
                    state_next = stat.last_in ? S_SHORT : S_FINISH;
                end
                else if (stat.count == 3'd3)
                begin
                    phase_next = PH_END0;
                    d2_next    = 1'b0;
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_EMIT_H1;
                end
            end
            S_EMIT_END:
            begin
                cmd.emit_src  = SRC_END;
                cmd.emit_last = (phase_reg == PH_END1);
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = (phase_reg == PH_END0) ? S_EMIT_H0 : S_FINISH;
                end
            end
            S_EMIT_H0:
            begin
                cmd.emit_src = SRC_H0;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_EMIT_H1;
                end
            end
            S_EMIT_H1:
            begin
                cmd.emit_src = SRC_H1;
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_in)
                    begin
                        phase_next = PH_END1;
                        d2_next    = 1'b0;
                        state_next = S_PREP;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SHORT:
            begin
                cmd.emit_src  = SRC_SHORT;
                cmd.emit_last = (idx_reg == stat.count[1:0]);
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (idx_reg == stat.count[1:0])
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_INT;
            d2_reg    <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            d2_reg    <= d2_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[sv/finite_difference_derivatives_core.sv]
// ----------------------------------------------------------------------------
// finite_difference_derivatives_core
// First and second derivatives of a streamed curve by central differences,
// with linearly extrapolated end values, in signed fixed point.
//
//   channel  dir  fields                                        transfer
//   in       in   x_sample y_sample last_point                  in_valid & in_ready
//   out      out  x_out first_deriv second_deriv status         out_valid & out_ready
//                 last_result
//
// Each quotient runs on one shared 43-step restoring divider, after operand
// setup and the multiply.
// in_ready is high only while no point is in work.
// Reset clears the sequencer, the point count and the output valid.
// A stalled output holds the sequencer before its next result transfer.
// ----------------------------------------------------------------------------
module finite_difference_derivatives_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] x_sample,
    input  logic signed [31:0] y_sample,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] x_out,
    output logic signed [31:0] first_deriv,
    output logic signed [31:0] second_deriv,
    output logic [1:0]         status,
    output logic               last_result
);
    import fdd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fdd_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .last_point   (last_point),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .x_out        (x_out),
        .first_deriv  (first_deriv),
        .second_deriv (second_deriv),
        .status       (status),
        .last_result  (last_result)
    );

endmodule

[sv/fdd_checker.sv]
// ----------------------------------------------------------------------------
// fdd_checker
// Port-level checks for the derivative core, bound to the top level.
// ----------------------------------------------------------------------------
module fdd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] x_out,
    input logic [31:0] first_deriv,
    input logic [31:0] second_deriv,
    input logic [1:0]  status,
    input logic        last_result
);
    import fdd_pkg::*;

    // stalled result holds its x, status, first derivative and last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(status)
            && $stable(first_deriv) && $stable(last_result))
    else $error("result changed while stalled");

    // one point in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while a point is in work");

    // short curves carry zero derivatives
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FEW) |-> (first_deriv == '0) && (second_deriv == '0))
    else $error("short curve result with nonzero derivative");

    // a new result never appears on the cycle after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared before any work");

endmodule

bind finite_difference_derivatives_core fdd_checker u_fdd_checker (.*);

[dv/tb_finite_difference_derivatives_core.sv]
// ----------------------------------------------------------------------------
// tb_finite_difference_derivatives_core
// Streams curves of (x, y) points into the derivative core and checks every
// result transfer against a cycle-free predictor of the central difference
// and end extrapolation arithmetic, under random idling and back pressure.
// ----------------------------------------------------------------------------
module tb_finite_difference_derivatives_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI   = 64'sd2147483647;
    localparam longint SAT_LO   = -64'sd2147483648;
    localparam longint QUOT_CAP = 64'sd1 << 40;
    localparam int     FRAC     = 16;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        logic               drain;
    } point_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] d1;
        logic [31:0] d2;
        logic [1:0]  st;
        logic        last;
    } deriv_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] x_sample;
    logic signed [31:0] y_sample;
    logic               last_point;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] x_out;
    logic signed [31:0] first_deriv;
    logic signed [31:0] second_deriv;
    logic [1:0]         status;
    logic               last_result;

    point_t pending_points[$];
    deriv_t expected_derivs[$];
    int     fail_count;
    int     results_seen;
    bit     in_fired;
    bit     out_fired;
    int     send_gap;
    int     recv_gap;
    int     long_hold;
    bit     long_hold_done;
    bit     recv_busy;

    // predictor state
    longint     px[4];
    longint     py[3];
    longint     hist_d1[2];
    longint     hist_d2[2];
    logic [1:0] hist_st[2];
    int         pt_count;

    finite_difference_derivatives_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_out        (x_out),
        .first_deriv  (first_deriv),
        .second_deriv (second_deriv),
        .status       (status),
        .last_result  (last_result)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [127:0] abs128(longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic void raise_st(inout logic [1:0] st, input logic [1:0] code);
        if (code > st)
            st = code;
    endfunction

    function automatic longint clamp32(longint v, inout logic [1:0] st);
        if (v > SAT_HI)
        begin
            raise_st(st, fdd_pkg::ST_SAT);
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            raise_st(st, fdd_pkg::ST_SAT);
            return SAT_LO;
        end
        return v;
    endfunction

    // truncating quotient, capped; zero divisor flags and, with a nonzero dividend, saturates by sign
    function automatic longint trunc_quot(bit neg, logic [127:0] num, logic [127:0] den,
                                          inout logic [1:0] st);
        logic [127:0] q;
        longint       m;
        if (num == 0)
        begin
            if (den == 0)
                raise_st(st, fdd_pkg::ST_ZDIV);
            return 0;
        end
        if (den == 0)
        begin
            raise_st(st, fdd_pkg::ST_ZDIV);
            return neg ? -QUOT_CAP : QUOT_CAP;
        end
        q = num / den;
        m = (q > 128'(QUOT_CAP)) ? QUOT_CAP : longint'(q);
        return neg ? -m : m;
    endfunction

    // central differences at the middle of three points
    function automatic void central_diff(longint xa, longint xb, longint xc, longint ya,
                                         longint yb, longint yc, output longint d1,
                                         output longint d2, output logic [1:0] st);
        longint dy;
        longint dx;
        longint nm;
        longint dxr;
        longint dxl;
        longint v;
        dy  = yc - ya;
        dx  = xc - xa;
        nm  = yc + ya - 2 * yb;
        dxr = xc - xb;
        dxl = xb - xa;
        st  = fdd_pkg::ST_OK;
        v   = trunc_quot((dy < 0) != (dx < 0), abs128(dy) << FRAC, abs128(dx), st);
        d1  = clamp32(v, st);
        v   = trunc_quot(((nm < 0) != (dxr < 0)) != (dxl < 0), abs128(nm) << (2 * FRAC),
                         abs128(dxr) * abs128(dxl), st);
        d2  = clamp32(v, st);
    endfunction

    function automatic longint linear_extrap(longint dnear, longint dfar, longint xnear,
                                             longint xfar, longint xt,
                                             inout logic [1:0] st);
        longint dd;
        longint dt;
        longint ds;
        longint q;
        dd = dfar - dnear;
        dt = xt - xnear;
        ds = xfar - xnear;
        q  = trunc_quot(((dd < 0) != (dt < 0)) != (ds < 0), abs128(dd) * abs128(dt),
                        abs128(ds), st);
        return clamp32(dnear + q, st);
    endfunction

    function automatic void push_deriv(longint x, longint d1, longint d2,
                                       logic [1:0] st, logic last);
        deriv_t r;
        r.x    = x[31:0];
        r.d1   = d1[31:0];
        r.d2   = d2[31:0];
        r.st   = st;
        r.last = last;
        expected_derivs.push_back(r);
    endfunction

    function automatic void push_end(int near, int far, longint xnear, longint xfar,
                                     longint xt, logic last);
        logic [1:0] st;
        longint     d1;
        longint     d2;
        st = fdd_pkg::ST_OK;
        raise_st(st, hist_st[0]);
        raise_st(st, hist_st[1]);
        d1 = linear_extrap(hist_d1[near], hist_d1[far], xnear, xfar, xt, st);
        d2 = linear_extrap(hist_d2[near], hist_d2[far], xnear, xfar, xt, st);
        push_deriv(xt, d1, d2, st, last);
    endfunction

    // expected results of one accepted point
    function automatic void predict_point(longint x, longint y, logic last);
        longint     nd1;
        longint     nd2;
        logic [1:0] ns;
        if (pt_count < 3)
        begin
            px[pt_count] = x;
            py[pt_count] = y;
            if (pt_count == 2)
                central_diff(px[0], px[1], px[2], py[0], py[1], py[2],
                             hist_d1[0], hist_d2[0], hist_st[0]);
            if (last)
            begin
                for (int i = 0; i <= pt_count; i++)
                    push_deriv(px[i], 0, 0, fdd_pkg::ST_FEW, i == pt_count);
                pt_count = 0;
            end
            else
                pt_count++;
            return;
        end
        px[3] = x;
        central_diff(px[1], px[2], x, py[1], py[2], y, nd1, nd2, ns);
        if (pt_count == 3)
        begin
            hist_d1[1] = nd1;
            hist_d2[1] = nd2;
            hist_st[1] = ns;
            push_end(0, 1, px[1], px[2], px[0], 1'b0);
            push_deriv(px[1], hist_d1[0], hist_d2[0], hist_st[0], 1'b0);
            push_deriv(px[2], nd1, nd2, ns, 1'b0);
        end
        else
        begin
            hist_d1[0] = hist_d1[1];
            hist_d2[0] = hist_d2[1];
            hist_st[0] = hist_st[1];
            hist_d1[1] = nd1;
            hist_d2[1] = nd2;
            hist_st[1] = ns;
            push_deriv(px[2], nd1, nd2, ns, 1'b0);
        end
        if (last)
            push_end(1, 0, px[2], px[1], x, 1'b1);
        px[0] = px[1];
        px[1] = px[2];
        px[2] = x;
        py[0] = py[1];
        py[1] = py[2];
        py[2] = y;
        pt_count = last ? 0 : 4;
    endfunction

    function automatic void add_point(logic [31:0] x, logic [31:0] y, logic last,
                                      logic drain = 1'b0);
        point_t p;
        p.x     = x;
        p.y     = y;
        p.last  = last;
        p.drain = drain;
        pending_points.push_back(p);
    endfunction

    // input transfers, prediction and result checks at the rising edge
    always @(posedge clk)
    begin
        deriv_t e;
        in_fired  = rst_n && in_valid && in_ready;
        out_fired = rst_n && out_valid && out_ready;
        if (in_fired)
            predict_point(longint'(x_sample), longint'(y_sample), last_point);
        if (out_fired)
        begin
            results_seen++;
            if (expected_derivs.size() == 0)
            begin
                $error("unexpected result transfer x_out=%0h", x_out);
                fail_count++;
            end
            else
            begin
                e = expected_derivs.pop_front();
                if (x_out !== e.x)
                begin
                    $error("x_out expected %0h actual %0h", e.x, x_out);
                    fail_count++;
                end
                if (first_deriv !== e.d1)
                begin
                    $error("first_deriv expected %0h actual %0h", e.d1, first_deriv);
                    fail_count++;
                end
                if (second_deriv !== e.d2)
                begin
                    $error("second_deriv expected %0h actual %0h", e.d2, second_deriv);
                    fail_count++;
                end
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    fail_count++;
                end
                if (last_result !== e.last)
                begin
                    $error("last_result expected %0d actual %0d", e.last, last_result);
                    fail_count++;
                end
            end
        end
    end

    // point driver
    always @(negedge clk)
    begin
        point_t p;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid)
        begin
            if (in_fired)
            begin
                in_valid <= 1'b0;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
        else if (send_gap > 0)
            send_gap <= send_gap - 1;
        else if (pending_points.size() > 0)
        begin
            // a marked point waits until every expected result has arrived
            if (!pending_points[0].drain || expected_derivs.size() == 0)
            begin
                p = pending_points.pop_front();
                x_sample   <= p.x;
                y_sample   <= p.y;
                last_point <= p.last;
                in_valid   <= 1'b1;
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        int g;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold > 0)
        begin
            out_ready <= 1'b0;
            long_hold <= long_hold - 1;
        end
        else if (!long_hold_done && results_seen >= 30)
        begin
            out_ready      <= 1'b0;
            long_hold      <= 3000;
            long_hold_done <= 1'b1;
        end
        else if (out_fired || !recv_busy)
        begin
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            out_ready <= (g == 0);
            recv_gap  <= g;
            recv_busy <= 1'b1;
        end
        else if (recv_gap > 1)
            recv_gap <= recv_gap - 1;
        else
            out_ready <= 1'b1;
    end

    // stimulus and end of test
    initial
    begin
        int     n;
        int     len;
        logic   smooth;
        longint xv;
        longint yv;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        x_sample       = '0;
        y_sample       = '0;
        last_point     = 1'b0;
        fail_count     = 0;
        results_seen   = 0;
        send_gap       = 0;
        recv_gap       = 0;
        recv_busy      = 1'b0;
        long_hold      = 0;
        long_hold_done = 1'b0;
        pt_count       = 0;
        foreach (px[i]) px[i] = 0;
        foreach (py[i]) py[i] = 0;
        foreach (hist_d1[i]) hist_d1[i] = 0;
        foreach (hist_d2[i]) hist_d2[i] = 0;
        foreach (hist_st[i]) hist_st[i] = fdd_pkg::ST_OK;

        // short curves of one, two and three points
        add_point(32'h7fffffff, 32'h80000000, 1'b1);
        add_point(32'h80000000, 32'h7fffffff, 1'b0);
        add_point(32'h00000000, 32'h00000000, 1'b1);
        add_point(32'h00010000, 32'h00010000, 1'b0);
        add_point(32'h00020000, 32'h00040000, 1'b0);
        add_point(32'h00030000, 32'h00090000, 1'b1);
        // smooth four-point curve
        add_point(32'h00000000, 32'h00000000, 1'b0);
        add_point(32'h00010000, 32'h00010000, 1'b0);
        add_point(32'h00020000, 32'h00040000, 1'b0);
        add_point(32'h00030000, 32'h00090000, 1'b1);
        // zero spacing: repeated x with equal and with differing y
        add_point(32'h00010000, 32'h00050000, 1'b0);
        add_point(32'h00010000, 32'h00050000, 1'b0);
        add_point(32'h00010000, 32'h00050000, 1'b0);
        add_point(32'h00020000, 32'hfffb0000, 1'b0);
        add_point(32'h00020000, 32'h00070000, 1'b1);
        // extremes: tiny spacing and full-swing y saturate
        add_point(32'h80000000, 32'h7fffffff, 1'b0);
        add_point(32'h80000001, 32'h80000000, 1'b0);
        add_point(32'h80000002, 32'h7fffffff, 1'b0);
        add_point(32'h7fffffff, 32'h80000000, 1'b0);
        add_point(32'h7ffffffe, 32'hffffffff, 1'b1, 1'b1);

        // random curves, mostly long and ordered, some short and some wild
        n = 0;
        while (n < 100)
        begin
            len    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(4, 10);
            smooth = $urandom_range(0, 4) != 0;
            xv     = longint'($signed(32'($urandom))) >>> $urandom_range(0, 16);
            yv     = longint'($signed(32'($urandom))) >>> $urandom_range(4, 16);
            for (int k = 0; k < len; k++)
            begin
                if (smooth)
                begin
                    xv += ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 300000);
                    yv += longint'($signed(32'($urandom))) >>> $urandom_range(8, 20);
                    add_point(xv[31:0], yv[31:0], k == len - 1, n == 60);
                end
                else
                    add_point($urandom, $urandom, k == len - 1, n == 60);
                n++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // last point offered, then taken, then all its results drained
        wait (pending_points.size() == 0);
        @(posedge clk);
        wait (!in_valid);
        wait (expected_derivs.size() == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && expected_derivs.size() == 0)
            $display("finite_difference_derivatives_core regression: pass");
        else
            $display("finite_difference_derivatives_core regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #1500000;
        $display("finite_difference_derivatives_core regression: fail");
        $finish;
    end

endmodule
